// File: rtl/gemm_pkg.sv
// Package with the types, codes and constants shared by the matrix multiply-accumulate block.
package gemm_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_LOAD_C = 2'd2,
    FUNC_RUN    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_ROWS  = 3'd0,
    CFG_INNER = 3'd1,
    CFG_COLS  = 3'd2,
    CFG_ALPHA = 3'd3,
    CFG_BETA  = 3'd4
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIM_W      = 4;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ACC_W      = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BETA,
    ST_ALPHA,
    ST_MAC,
    ST_EMIT
  } eng_state_t;

  // Command passed from the front end to the engine.
  typedef struct packed {
    func_t            func;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

// File: rtl/general_matrix_multiply_accumulate_top.sv
// Top level of the matrix multiply-accumulate block: configuration registers and wiring.
// Computes C = beta*C + alpha*A*B on 8x8 stores in signed fixed point. A load beat is taken
// through a two-entry command queue. A compute beat occupies the shared multiplier: first
// beta scales each C element, then alpha scales each A element before its A*B terms are
// accumulated, then each result element is emitted.
module general_matrix_multiply_accumulate_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [gemm_pkg::IDX_W-1:0]        in_row_index,
  input  logic [gemm_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [gemm_pkg::VAL_W-1:0] in_elem_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gemm_pkg::IDX_W-1:0]        out_out_row,
  output logic [gemm_pkg::IDX_W-1:0]        out_out_col,
  output logic signed [gemm_pkg::VAL_W-1:0] out_out_value,
  output logic                              out_last_flag,
  input  logic                              cfg_we,
  input  logic [gemm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gemm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gemm_pkg::*;

  logic [DIM_W-1:0]        m_r, k_r, n_r;
  logic signed [VAL_W-1:0] alpha_r, beta_r;
  logic                    q_valid, q_pop;
  cmd_t                    q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= DIM_W'(8); k_r <= DIM_W'(8); n_r <= DIM_W'(8);
      alpha_r <= VAL_W'(64'sd1 <<< FRAC_BITS);
      beta_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS:  m_r <= cfg_data[DIM_W-1:0];
        CFG_INNER: k_r <= cfg_data[DIM_W-1:0];
        CFG_COLS:  n_r <= cfg_data[DIM_W-1:0];
        CFG_ALPHA: alpha_r <= cfg_data;
        CFG_BETA:  beta_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gemm_front #(.DEPTH(2)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_row_index, .in_col_index,
    .in_elem_value, .dim_m(m_r), .dim_k(k_r), .dim_n(n_r),
    .q_valid, .q_pop, .q_cmd
  );

  gemm_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .dim_m(m_r), .dim_k(k_r), .dim_n(n_r), .alpha(alpha_r), .beta(beta_r),
    .out_valid, .out_stall, .out_out_row, .out_out_col, .out_out_value, .out_last_flag
  );
endmodule

// File: rtl/gemm_front.sv
// Front end: accepts input beats, drops out-of-range loads and queues commands.
module gemm_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [gemm_pkg::IDX_W-1:0]     in_row_index,
  input  logic [gemm_pkg::IDX_W-1:0]     in_col_index,
  input  logic signed [gemm_pkg::VAL_W-1:0] in_elem_value,
  input  logic [gemm_pkg::DIM_W-1:0]     dim_m,
  input  logic [gemm_pkg::DIM_W-1:0]     dim_k,
  input  logic [gemm_pkg::DIM_W-1:0]     dim_n,
  output logic                           q_valid,
  input  logic                           q_pop,
  output gemm_pkg::cmd_t                 q_cmd
);
  import gemm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [PTR_W:0]    cnt_r;
  logic              push, keep;
  func_t             f;
  logic [DIM_W-1:0]  rlim, clim;

  // A dimension register of zero behaves as one.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    return (d == '0) ? DIM_W'(1) : d;
  endfunction

  assign f = func_t'(in_func);

  always_comb begin
    rlim = eff_dim(dim_m);
    clim = eff_dim(dim_n);
    case (f)
      FUNC_LOAD_A: clim = eff_dim(dim_k);
      FUNC_LOAD_B: rlim = eff_dim(dim_k);
      default: ;
    endcase
    keep = (f == FUNC_RUN) ||
           (({1'b0, in_row_index} < rlim) && ({1'b0, in_col_index} < clim));
  end

  assign in_stall = (cnt_r == (PTR_W+1)'(DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{func: f, row: in_row_index, col: in_col_index,
                       value: in_elem_value};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)
        wp_r <= (wp_r == PTR_W'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop && q_valid)
        rp_r <= (rp_r == PTR_W'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop && q_valid);
    end
  end
endmodule

// File: rtl/gemm_engine.sv
// Back end: matrix stores, multiply-accumulate sequencer and result output register.
module gemm_engine #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  gemm_pkg::cmd_t                  q_cmd,
  input  logic [gemm_pkg::DIM_W-1:0]      dim_m,
  input  logic [gemm_pkg::DIM_W-1:0]      dim_k,
  input  logic [gemm_pkg::DIM_W-1:0]      dim_n,
  input  logic signed [gemm_pkg::VAL_W-1:0] alpha,
  input  logic signed [gemm_pkg::VAL_W-1:0] beta,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gemm_pkg::IDX_W-1:0]      out_out_row,
  output logic [gemm_pkg::IDX_W-1:0]      out_out_col,
  output logic signed [gemm_pkg::VAL_W-1:0] out_out_value,
  output logic                            out_last_flag
);
  import gemm_pkg::*;

  localparam int unsigned AD = 6;
  localparam logic signed [VAL_W:0] ONE = (VAL_W+1)'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [63:0] RND =
    (FRAC_BITS == 0) ? 64'sd0 : (64'sd1 <<< ((FRAC_BITS == 0) ? 0 : FRAC_BITS - 1));

  logic signed [VAL_W-1:0] a_mem [64];
  logic signed [VAL_W-1:0] b_mem [64];
  logic signed [VAL_W-1:0] c_mem [64];
  logic signed [ACC_W-1:0] acc_mem [64];

  eng_state_t st_r, st_nxt;
  logic [IDX_W-1:0] i_r, k_r, j_r;
  logic [IDX_W-1:0] i_nxt, k_nxt, j_nxt;
  logic [1:0]       ph_r, ph_nxt;   // sub-step within one element
  logic signed [VAL_W-1:0] ra_r, rb_r, rc_r, aik_r;
  logic signed [63:0]      prod_r;
  logic signed [ACC_W-1:0] racc_r;
  logic [IDX_W-1:0] mm, kk, nn;
  logic ov_r, emit_go;
  logic [AD-1:0] ik, kj, ij;

  function automatic logic [IDX_W-1:0] lastof(input logic [DIM_W-1:0] d);
    if (d == '0) return '0;
    if (d > DIM_W'(8)) return IDX_W'(7);
    return IDX_W'(d - 1'b1);
  endfunction

  function automatic logic signed [63:0] rshift(input logic signed [63:0] v);
    return (v + RND) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -(ACC_W'(64'sd2147483648))) return 32'sh80000000;
    return v[VAL_W-1:0];
  endfunction

  assign mm = lastof(dim_m);
  assign kk = lastof(dim_k);
  assign nn = lastof(dim_n);
  assign ik = {i_r, k_r};
  assign kj = {k_r, j_r};
  assign ij = {i_r, j_r};
  assign emit_go = !ov_r || !out_stall;

  assign q_pop = (st_r == ST_IDLE) && q_valid;

  // Memory reads registered each cycle at the sequencer's addresses.
  always_ff @(posedge clk) begin
    ra_r   <= a_mem[ik];
    rb_r   <= b_mem[kj];
    rc_r   <= c_mem[ij];
    racc_r <= acc_mem[ij];
  end

  always_comb begin
    st_nxt = st_r;
    i_nxt = i_r; k_nxt = k_r; j_nxt = j_r; ph_nxt = ph_r + 2'd1;
    unique case (st_r)
      ST_IDLE: begin
        ph_nxt = '0;
        if (q_valid && q_cmd.func == FUNC_RUN) begin
          st_nxt = ST_BETA; i_nxt = '0; j_nxt = '0; k_nxt = '0;
        end
      end
      ST_BETA: if (ph_r == 2'd2) begin
        ph_nxt = '0;
        if (j_r == nn) begin
          j_nxt = '0;
          if (i_r == mm) begin i_nxt = '0; st_nxt = ST_ALPHA; end
          else i_nxt = i_r + 1'b1;
        end else j_nxt = j_r + 1'b1;
      end
      ST_ALPHA: if (ph_r == 2'd2) begin
        ph_nxt = '0; j_nxt = '0; st_nxt = ST_MAC;
      end
      ST_MAC: if (ph_r == 2'd3) begin
        ph_nxt = '0;
        if (j_r == nn) begin
          j_nxt = '0;
          if (k_r == kk) begin
            k_nxt = '0;
            if (i_r == mm) begin i_nxt = '0; st_nxt = ST_EMIT; end
            else begin i_nxt = i_r + 1'b1; st_nxt = ST_ALPHA; end
          end else begin k_nxt = k_r + 1'b1; st_nxt = ST_ALPHA; end
        end else j_nxt = j_r + 1'b1;
      end
      ST_EMIT: begin
        if (ph_r == '0) ph_nxt = 2'd1;
        else if (emit_go) begin
          ph_nxt = '0;
          if (j_r == nn) begin
            j_nxt = '0;
            if (i_r == mm) begin i_nxt = '0; st_nxt = ST_IDLE; end
            else i_nxt = i_r + 1'b1;
          end else j_nxt = j_r + 1'b1;
        end else ph_nxt = ph_r;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    // loads
    if (st_r == ST_IDLE && q_valid) begin
      unique case (q_cmd.func)
        FUNC_LOAD_A: a_mem[{q_cmd.row, q_cmd.col}] <= q_cmd.value;
        FUNC_LOAD_B: b_mem[{q_cmd.row, q_cmd.col}] <= q_cmd.value;
        FUNC_LOAD_C: c_mem[{q_cmd.row, q_cmd.col}] <= q_cmd.value;
        default: ;
      endcase
    end
    // beta: phase 1 multiply, phase 2 write
    if (st_r == ST_BETA && ph_r == 2'd1)
      prod_r <= 64'(rc_r) * 64'(beta);
    if (st_r == ST_BETA && ph_r == 2'd2) begin
      if (beta == '0) acc_mem[ij] <= '0;
      else if ({beta[VAL_W-1], beta} == ONE) acc_mem[ij] <= ACC_W'(rc_r);
      else acc_mem[ij] <= ACC_W'(rshift(prod_r));
    end
    if (st_r == ST_ALPHA && ph_r == 2'd1)
      prod_r <= 64'(ra_r) * 64'(alpha);
    if (st_r == ST_ALPHA && ph_r == 2'd2)
      aik_r <= sat(ACC_W'(rshift(prod_r)));
    if (st_r == ST_MAC && ph_r == 2'd1)
      prod_r <= 64'(aik_r) * 64'(rb_r);
    if (st_r == ST_MAC && ph_r == 2'd3)
      acc_mem[ij] <= racc_r + ACC_W'(rshift(prod_r));
    if (st_r == ST_EMIT && ph_r == 2'd1 && emit_go) begin
      c_mem[ij]     <= sat(racc_r);
      out_out_row   <= i_r;
      out_out_col   <= j_r;
      out_out_value <= sat(racc_r);
      out_last_flag <= (i_r == mm) && (j_r == nn);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ph_r <= '0;
      i_r <= '0; k_r <= '0; j_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      i_r <= i_nxt; k_r <= k_nxt; j_r <= j_nxt;
      if (st_r == ST_EMIT && ph_r == 2'd1 && emit_go) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;
endmodule
